// File: rtl/temperature_band_statistics_macros.svh
// Assertion helpers for the temperature band statistics block.
// Define ASSERT_OFF to compile them out.
`ifndef TEMPERATURE_BAND_STATISTICS_MACROS_SVH
`define TEMPERATURE_BAND_STATISTICS_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbs: assertion failed");

// next-cycle implication
`define TBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbs: assertion failed");

`else

`define TBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/tbs_pkg.sv
package tbs_pkg;

    // field widths
    localparam int RD_W      = 16;
    localparam int VAL_W     = 15;
    localparam int CNT_OUT_W = 11;
    localparam int IDX_W     = 10;
    localparam int SUM_W     = 25;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};

    // register file
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_WARNING  = 2'd0;
    localparam logic [1:0] REG_CRITICAL = 2'd1;
    localparam logic [1:0] REG_SHUTDOWN = 2'd2;

    localparam logic [VAL_W-1:0] WARNING_RST  = 15'd480;
    localparam logic [VAL_W-1:0] CRITICAL_RST = 15'd720;
    localparam logic [VAL_W-1:0] SHUTDOWN_RST = 15'd960;

    typedef struct packed {
        logic [VAL_W-1:0] warning;
        logic [VAL_W-1:0] critical;
        logic [VAL_W-1:0] shutdown;
    } t_thresh;

    // controller states
    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_START,
        ST_DIV
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: rtl/temperature_band_statistics.sv
// Channel   Handshake              Payload
// input     i_valid / o_stall      i_reading, i_batch_end
// output    o_valid / i_stall      o_valid_count ... o_first_critical_value
// config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// Readings are taken one per cycle while a batch is open.
// After the item with i_batch_end, the sum/count divider runs, one quotient bit per
// cycle; the next batch opens once the quotient is final and the output register is free.
// The summary sits in an output register; the next batch streams in while
// it waits. A new summary waits until the previous one is taken.
// Synchronous active-low reset restores 30/45/60 C thresholds, clears the batch.
module temperature_band_statistics #(
    parameter int MAX_READINGS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [tbs_pkg::RD_W-1:0]   i_reading,
    input  logic                              i_batch_end,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tbs_pkg::CNT_OUT_W-1:0]     o_valid_count,
    output logic [tbs_pkg::CNT_OUT_W-1:0]     o_skip_count,
    output logic [tbs_pkg::VAL_W-1:0]         o_min_reading,
    output logic [tbs_pkg::VAL_W-1:0]         o_max_reading,
    output logic [tbs_pkg::VAL_W-1:0]         o_average_reading,
    output logic [tbs_pkg::CNT_OUT_W-1:0]     o_normal_count,
    output logic [tbs_pkg::CNT_OUT_W-1:0]     o_warning_count,
    output logic [tbs_pkg::CNT_OUT_W-1:0]     o_critical_count,
    output logic [tbs_pkg::CNT_OUT_W-1:0]     o_shutdown_count,
    output logic                              o_first_critical_found,
    output logic [tbs_pkg::IDX_W-1:0]         o_first_critical_index,
    output logic [tbs_pkg::VAL_W-1:0]         o_first_critical_value,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tbs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tbs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tbs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import tbs_pkg::*;

    t_thresh thr;
    t_cmd    cmd;
    t_status status;

    // threshold registers
    tbs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (thr)
    );

    // sequencer
    tbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_batch_end (i_batch_end),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    // accumulators, divider, result register
    tbs_dp #(
        .MAX_READINGS (MAX_READINGS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_reading              (i_reading),
        .i_thr                  (thr),
        .i_cmd                  (cmd),
        .i_stall                (i_stall),
        .o_status               (status),
        .o_valid                (o_valid),
        .o_valid_count          (o_valid_count),
        .o_skip_count           (o_skip_count),
        .o_min_reading          (o_min_reading),
        .o_max_reading          (o_max_reading),
        .o_average_reading      (o_average_reading),
        .o_normal_count         (o_normal_count),
        .o_warning_count        (o_warning_count),
        .o_critical_count       (o_critical_count),
        .o_shutdown_count       (o_shutdown_count),
        .o_first_critical_found (o_first_critical_found),
        .o_first_critical_index (o_first_critical_index),
        .o_first_critical_value (o_first_critical_value)
    );

endmodule

// File: rtl/tbs_regs.sv
module tbs_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tbs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tbs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tbs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output tbs_pkg::t_thresh                  o_thr
);
    import tbs_pkg::*;

    t_thresh          r_thr;
    t_thresh          n_thr;
    logic             wr_en;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    // register writes
    always_comb begin
        n_thr = r_thr;
        if (wr_en) begin
            case (reg_sel)
                REG_WARNING:  n_thr.warning  = pwdata[VAL_W-1:0];
                REG_CRITICAL: n_thr.critical = pwdata[VAL_W-1:0];
                REG_SHUTDOWN: n_thr.shutdown = pwdata[VAL_W-1:0];
                default:      n_thr = r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.warning  <= WARNING_RST;
            r_thr.critical <= CRITICAL_RST;
            r_thr.shutdown <= SHUTDOWN_RST;
        end else begin
            r_thr <= n_thr;
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            REG_WARNING:  prdata = APB_DATA_W'(r_thr.warning);
            REG_CRITICAL: prdata = APB_DATA_W'(r_thr.critical);
            REG_SHUTDOWN: prdata = APB_DATA_W'(r_thr.shutdown);
            default:      prdata = '0;
        endcase
    end

    assign o_thr = r_thr;

endmodule

// File: rtl/tbs_div.sv
module tbs_div #(
    parameter int DEN_W = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tbs_pkg::SUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]           i_den,
    output logic                       o_busy,
    output logic [tbs_pkg::SUM_W-1:0]  o_quot
);
    import tbs_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                r_busy;
    logic                n_busy;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic [SUM_W-1:0]    r_q;
    logic [SUM_W-1:0]    n_q;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    n_rem;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    n_den;
    logic [DEN_W:0]      trial;
    logic                fits;

    // one restoring step per cycle: numerator shifts out, quotient shifts in
    assign trial = {r_rem, r_q[SUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(SUM_W);
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_q    = {r_q[SUM_W-2:0], fits};
            n_rem  = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_step = r_step - STEP_W'(1);
            n_busy = (r_step != STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

// File: rtl/tbs_dp.sv
`include "temperature_band_statistics_macros.svh"
module tbs_dp #(
    parameter int MAX_READINGS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [tbs_pkg::RD_W-1:0] i_reading,
    input  tbs_pkg::t_thresh                i_thr,
    input  tbs_pkg::t_cmd                   i_cmd,
    input  logic                            i_stall,
    output tbs_pkg::t_status                o_status,
    output logic                            o_valid,
    output logic [tbs_pkg::CNT_OUT_W-1:0]   o_valid_count,
    output logic [tbs_pkg::CNT_OUT_W-1:0]   o_skip_count,
    output logic [tbs_pkg::VAL_W-1:0]       o_min_reading,
    output logic [tbs_pkg::VAL_W-1:0]       o_max_reading,
    output logic [tbs_pkg::VAL_W-1:0]       o_average_reading,
    output logic [tbs_pkg::CNT_OUT_W-1:0]   o_normal_count,
    output logic [tbs_pkg::CNT_OUT_W-1:0]   o_warning_count,
    output logic [tbs_pkg::CNT_OUT_W-1:0]   o_critical_count,
    output logic [tbs_pkg::CNT_OUT_W-1:0]   o_shutdown_count,
    output logic                            o_first_critical_found,
    output logic [tbs_pkg::IDX_W-1:0]       o_first_critical_index,
    output logic [tbs_pkg::VAL_W-1:0]       o_first_critical_value
);
    import tbs_pkg::*;

    localparam int                CW      = $clog2(MAX_READINGS + 1);
    localparam logic [CW-1:0]     CNT_MAX = CW'(MAX_READINGS);
    localparam logic [CW-1:0]     POS_MAX = CW'(MAX_READINGS - 1);

    // batch accumulators
    logic [CW-1:0]       r_pos,   n_pos;
    logic [CW-1:0]       r_vtot,  n_vtot;
    logic [CW-1:0]       r_etot,  n_etot;
    logic [CW-1:0]       r_band [4];
    logic [CW-1:0]       n_band [4];
    logic [VAL_W-1:0]    r_min,   n_min;
    logic [VAL_W-1:0]    r_max,   n_max;
    logic [SUM_W-1:0]    r_sum,   n_sum;
    logic                r_crit_seen, n_crit_seen;
    logic [IDX_W-1:0]    r_crit_idx,  n_crit_idx;
    logic [VAL_W-1:0]    r_crit_val,  n_crit_val;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [CNT_OUT_W-1:0] r_o_vcnt, r_o_ecnt;
    logic [CNT_OUT_W-1:0] r_o_band [4];
    logic [VAL_W-1:0]    r_o_min, r_o_max, r_o_avg, r_o_cval;
    logic                r_o_cfound;
    logic [IDX_W-1:0]    r_o_cidx;

    logic                is_err;
    logic [VAL_W-1:0]    val;
    logic [3:0]          band_hit;
    logic                ge_warn, ge_crit, ge_shut;
    logic [SUM_W:0]      sum_ext;
    logic [CW-1:0]       pos_clamp;
    logic                div_busy;
    logic [SUM_W-1:0]    quot;
    logic [VAL_W-1:0]    avg;
    logic                out_free;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c < CNT_MAX) ? c + CW'(1) : c;
    endfunction

    // band classification, shutdown first
    assign is_err  = i_reading[RD_W-1];
    assign val     = i_reading[VAL_W-1:0];
    assign ge_shut = val >= i_thr.shutdown;
    assign ge_crit = val >= i_thr.critical;
    assign ge_warn = val >= i_thr.warning;
    assign band_hit[3] = ge_shut;
    assign band_hit[2] = !ge_shut && ge_crit;
    assign band_hit[1] = !ge_shut && !ge_crit && ge_warn;
    assign band_hit[0] = !ge_shut && !ge_crit && !ge_warn;

    assign sum_ext   = {1'b0, r_sum} + (SUM_W+1)'(val);
    assign pos_clamp = (r_pos > POS_MAX) ? POS_MAX : r_pos;

    // accumulate one item, or clear once the result is loaded
    always_comb begin
        n_pos       = r_pos;
        n_vtot      = r_vtot;
        n_etot      = r_etot;
        n_band      = r_band;
        n_min       = r_min;
        n_max       = r_max;
        n_sum       = r_sum;
        n_crit_seen = r_crit_seen;
        n_crit_idx  = r_crit_idx;
        n_crit_val  = r_crit_val;
        if (i_cmd.load_out) begin
            n_pos       = '0;
            n_vtot      = '0;
            n_etot      = '0;
            for (int b = 0; b < 4; b++) begin
                n_band[b] = '0;
            end
            n_min       = VAL_MAX;
            n_max       = '0;
            n_sum       = '0;
            n_crit_seen = 1'b0;
            n_crit_idx  = '0;
            n_crit_val  = '0;
        end else if (i_cmd.acc_en) begin
            n_pos = sat_inc(r_pos);
            if (is_err) begin
                n_etot = sat_inc(r_etot);
            end else begin
                for (int b = 0; b < 4; b++) begin
                    if (band_hit[b]) begin
                        n_band[b] = sat_inc(r_band[b]);
                    end
                end
                n_vtot = sat_inc(r_vtot);
                if (val < r_min) begin
                    n_min = val;
                end
                if (val > r_max) begin
                    n_max = val;
                end
                n_sum = sum_ext[SUM_W] ? SUM_CAP : sum_ext[SUM_W-1:0];
                if (!r_crit_seen && ge_crit) begin
                    n_crit_seen = 1'b1;
                    n_crit_idx  = IDX_W'(pos_clamp);
                    n_crit_val  = val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_vtot      <= '0;
            r_etot      <= '0;
            for (int b = 0; b < 4; b++) begin
                r_band[b] <= '0;
            end
            r_min       <= VAL_MAX;
            r_max       <= '0;
            r_sum       <= '0;
            r_crit_seen <= 1'b0;
            r_crit_idx  <= '0;
            r_crit_val  <= '0;
        end else begin
            r_pos       <= n_pos;
            r_vtot      <= n_vtot;
            r_etot      <= n_etot;
            r_band      <= n_band;
            r_min       <= n_min;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_crit_seen <= n_crit_seen;
            r_crit_idx  <= n_crit_idx;
            r_crit_val  <= n_crit_val;
        end
    end

    // average: sum / valid count
    tbs_div #(
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_sum),
        .i_den   (r_vtot),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign avg = (quot > SUM_W'(VAL_MAX)) ? VAL_MAX : quot[VAL_W-1:0];

    // result register, free when empty or being taken
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_vcnt   <= CNT_OUT_W'(r_vtot);
            r_o_ecnt   <= CNT_OUT_W'(r_etot);
            for (int b = 0; b < 4; b++) begin
                r_o_band[b] <= CNT_OUT_W'(r_band[b]);
            end
            r_o_min    <= (r_vtot == '0) ? '0 : r_min;
            r_o_max    <= (r_vtot == '0) ? '0 : r_max;
            r_o_avg    <= (r_vtot == '0) ? '0 : avg;
            r_o_cfound <= r_crit_seen;
            r_o_cidx   <= r_crit_idx;
            r_o_cval   <= r_crit_val;
        end
    end

    assign o_status.div_done = !div_busy;
    assign o_status.out_free = out_free;

    assign o_valid                = r_out_valid;
    assign o_valid_count          = r_o_vcnt;
    assign o_skip_count           = r_o_ecnt;
    assign o_min_reading          = r_o_min;
    assign o_max_reading          = r_o_max;
    assign o_average_reading      = r_o_avg;
    assign o_normal_count         = r_o_band[0];
    assign o_warning_count        = r_o_band[1];
    assign o_critical_count       = r_o_band[2];
    assign o_shutdown_count       = r_o_band[3];
    assign o_first_critical_found = r_o_cfound;
    assign o_first_critical_index = r_o_cidx;
    assign o_first_critical_value = r_o_cval;

    // accumulators hold still while the divider works
    `TBS_ASSERT_IMP(a_acc_not_dividing, i_clk, i_rst_n, i_cmd.acc_en, !div_busy)
    // a pending result is never overwritten, and the quotient is final
    `TBS_ASSERT_IMP(a_load_safe, i_clk, i_rst_n, i_cmd.load_out, out_free && !div_busy)
    // loading the result starts a fresh batch
    `TBS_ASSERT_NXT(a_load_clears, i_clk, i_rst_n, i_cmd.load_out,
                    r_out_valid && r_vtot == '0 && r_pos == '0)
    // no valid reading means no max, no sum, no critical capture
    `TBS_ASSERT_IMP(a_empty_batch, i_clk, i_rst_n, r_vtot == '0,
                    r_max == '0 && r_sum == '0 && !r_crit_seen)

endmodule

// File: rtl/tbs_ctrl.sv
module tbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_batch_end,
    input  tbs_pkg::t_status  i_status,
    output logic              o_stall,
    output tbs_pkg::t_cmd     o_cmd
);
    import tbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        o_cmd   = '0;
        case (r_state)
            ST_ACCUM: begin
                o_stall      = 1'b0;
                o_cmd.acc_en = i_valid;
                if (i_valid && i_batch_end) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done && i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

endmodule
